/* design/isp_pkg.sv */
// Shared types and constants for the integer string parser.
package isp_pkg;

    localparam int          QUEUE_DEPTH_DEF   = 4;
    localparam logic [6:0]  RESULT_BITS_RESET = 7'd64;
    localparam logic [6:0]  RESULT_BITS_MIN   = 7'd2;
    localparam logic [6:0]  RESULT_BITS_MAX   = 7'd64;
    // largest accumulator that can still take one more decimal digit
    localparam logic [63:0] DEC_OVF_LIMIT     = 64'd1844674407370955161;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_UC_X  = 8'h58;
    localparam logic [7:0] CHAR_LC_X  = 8'h78;
    localparam logic [7:0] CHAR_UC_O  = 8'h4F;
    localparam logic [7:0] CHAR_LC_O  = 8'h6F;
    localparam logic [7:0] CHAR_UC_B  = 8'h42;
    localparam logic [7:0] CHAR_LC_B  = 8'h62;
    localparam logic [7:0] CHAR_UC_U  = 8'h55;
    localparam logic [7:0] CHAR_LC_U  = 8'h75;

    typedef enum logic [2:0] {
        PH_SIGN   = 3'd0,
        PH_AFTSGN = 3'd1,
        PH_ZERO   = 3'd2,
        PH_FIRST  = 3'd3,
        PH_DIGITS = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_BIN = 2'd3
    } t_radix;

    typedef struct packed {
        logic       is_end;
        logic       is_minus;
        logic       is_plus;
        logic       is_zero;
        logic       is_under;
        logic       is_prefix;
        t_radix     prefix_radix;
        logic       is_digit;
        logic [3:0] digit;
    } t_token;

endpackage

/* design/isp_front.sv */
// Front end: classifies each accepted character item into a token.
module isp_front
    import isp_pkg::*;
(
    input  logic [7:0] i_char_code,
    input  logic       i_is_end,
    input  logic       i_push,
    input  logic       i_queue_full,
    output logic       o_queue_push,
    output t_token     o_token
);

    assign o_queue_push = i_push && !i_queue_full;

    always_comb begin
        o_token              = '0;
        o_token.is_end       = i_is_end;
        o_token.is_minus     = (i_char_code == CHAR_MINUS);
        o_token.is_plus      = (i_char_code == CHAR_PLUS);
        o_token.is_zero      = (i_char_code == CHAR_ZERO);
        o_token.is_under     = (i_char_code == CHAR_UNDER);
        o_token.prefix_radix = RADIX_DEC;
        o_token.is_prefix    = 1'b0;
        if (i_char_code == CHAR_UC_X || i_char_code == CHAR_LC_X) begin
            o_token.is_prefix    = 1'b1;
            o_token.prefix_radix = RADIX_HEX;
        end else if (i_char_code == CHAR_UC_O || i_char_code == CHAR_LC_O) begin
            o_token.is_prefix    = 1'b1;
            o_token.prefix_radix = RADIX_OCT;
        end else if (i_char_code == CHAR_UC_B || i_char_code == CHAR_LC_B) begin
            o_token.is_prefix    = 1'b1;
            o_token.prefix_radix = RADIX_BIN;
        end else if (i_char_code == CHAR_UC_U || i_char_code == CHAR_LC_U) begin
            o_token.is_prefix    = 1'b1;
            o_token.prefix_radix = RADIX_DEC;
        end
        case (i_char_code) inside
            [8'h30:8'h39]: begin
                o_token.is_digit = 1'b1;
                o_token.digit    = 4'(i_char_code - CHAR_ZERO);
            end
            [8'h41:8'h46]: begin
                o_token.is_digit = 1'b1;
                o_token.digit    = 4'(i_char_code - CHAR_UC_A + 8'd10);
            end
            [8'h61:8'h66]: begin
                o_token.is_digit = 1'b1;
                o_token.digit    = 4'(i_char_code - CHAR_LC_A + 8'd10);
            end
            default: begin
                o_token.is_digit = 1'b0;
                o_token.digit    = 4'd0;
            end
        endcase
    end

endmodule

/* design/isp_queue.sv */
// Small token queue between front end and back end.
module isp_queue
    import isp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_data,
    input  logic   i_pop,
    output t_token o_data,
    output logic   o_full,
    output logic   o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_token        r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count above depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FULL_CNT) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");

endmodule

/* design/isp_back.sv */
// Back end: parser state, digit accumulation, final range check, result register.
module isp_back
    import isp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [6:0]  i_result_bits,
    input  t_token      i_token,
    input  logic        i_token_valid,
    output logic        o_token_pop,
    input  logic        i_out_pop,
    output logic        o_out_valid,
    output logic [63:0] o_value_bits,
    output logic        o_parse_error
);

    t_phase      r_phase, n_phase;
    t_radix      r_radix, n_radix;
    logic        r_unsigned, n_unsigned;
    logic        r_negative, n_negative;
    logic [63:0] r_acc, n_acc;
    logic        r_err, n_err;

    logic        r_out_valid;
    logic [63:0] r_out_value;
    logic        r_out_err;

    logic        take, take_end, out_free;
    logic        digit_ok, dec_digit;
    logic        ovf_pre, add_ovf;
    logic [63:0] prod;
    logic [64:0] sum;
    logic [6:0]  nb;
    logic [5:0]  nb_m1;
    logic        fail_u, over_s, exact_s, range_ok, fin_ok;
    logic [63:0] fin_mag, fin_value;

    assign out_free    = !r_out_valid || i_out_pop;
    assign take        = i_token_valid && (!i_token.is_end || out_free);
    assign take_end    = take && i_token.is_end;
    assign o_token_pop = take;

    // digit test against current radix
    assign dec_digit = i_token.is_digit && (i_token.digit < 4'd10);
    always_comb begin
        case (r_radix)
            RADIX_HEX: digit_ok = i_token.is_digit;
            RADIX_OCT: digit_ok = i_token.is_digit && (i_token.digit < 4'd8);
            RADIX_BIN: digit_ok = i_token.is_digit && (i_token.digit < 4'd2);
            default:   digit_ok = dec_digit;
        endcase
    end

    // acc * radix + digit, with overflow
    always_comb begin
        case (r_radix)
            RADIX_HEX: begin
                ovf_pre = (r_acc[63:60] != 4'd0);
                prod    = r_acc << 4;
            end
            RADIX_OCT: begin
                ovf_pre = (r_acc[63:61] != 3'd0);
                prod    = r_acc << 3;
            end
            RADIX_BIN: begin
                ovf_pre = r_acc[63];
                prod    = r_acc << 1;
            end
            default: begin
                ovf_pre = (r_acc > DEC_OVF_LIMIT);
                prod    = (r_acc << 3) + (r_acc << 1);
            end
        endcase
        sum     = {1'b0, prod} + 65'(i_token.digit);
        add_ovf = ovf_pre || sum[64];
    end

    // parser next state
    always_comb begin
        n_phase    = r_phase;
        n_radix    = r_radix;
        n_unsigned = r_unsigned;
        n_negative = r_negative;
        n_acc      = r_acc;
        n_err      = r_err;
        if (take_end) begin
            n_phase    = PH_SIGN;
            n_radix    = RADIX_DEC;
            n_unsigned = 1'b0;
            n_negative = 1'b0;
            n_acc      = '0;
            n_err      = 1'b0;
        end else if (take && !r_err) begin
            case (r_phase)
                PH_SIGN, PH_AFTSGN: begin
                    if (r_phase == PH_SIGN && i_token.is_minus) begin
                        n_negative = 1'b1;
                        n_phase    = PH_AFTSGN;
                    end else if (r_phase == PH_SIGN && i_token.is_plus) begin
                        n_phase = PH_AFTSGN;
                    end else if (i_token.is_zero) begin
                        n_phase = PH_ZERO;
                    end else if (dec_digit) begin
                        n_acc   = 64'(i_token.digit);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (i_token.is_prefix) begin
                        n_radix    = i_token.prefix_radix;
                        n_unsigned = 1'b1;
                        n_phase    = PH_FIRST;
                    end else begin
                        n_phase = PH_DIGITS;
                        n_acc   = '0;
                        if (dec_digit) begin
                            n_acc = 64'(i_token.digit);
                        end else if (!i_token.is_under) begin
                            n_err = 1'b1;
                        end
                    end
                end
                PH_FIRST: begin
                    if (digit_ok) begin
                        n_acc   = 64'(i_token.digit);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    if (i_token.is_under) begin
                        n_acc = r_acc;
                    end else if (!digit_ok || add_ovf) begin
                        n_err = 1'b1;
                    end else begin
                        n_acc = sum[63:0];
                    end
                end
                default: n_err = 1'b1;
            endcase
        end
    end

    // end-of-string result
    always_comb begin
        if (i_result_bits < RESULT_BITS_MIN) begin
            nb = RESULT_BITS_MIN;
        end else if (i_result_bits > RESULT_BITS_MAX) begin
            nb = RESULT_BITS_MAX;
        end else begin
            nb = i_result_bits;
        end
        nb_m1   = 6'(nb - 7'd1);
        fail_u  = (nb != RESULT_BITS_MAX) && ((r_acc >> nb[5:0]) != 64'd0);
        over_s  = ((r_acc >> nb_m1) != 64'd0);
        exact_s = (r_acc == (64'd1 << nb_m1));
        if (r_unsigned) begin
            range_ok = !fail_u;
        end else if (r_negative) begin
            range_ok = !over_s || exact_s;
        end else begin
            range_ok = !over_s;
        end
        fin_ok    = !r_err && ((r_phase == PH_ZERO) ||
                               (r_phase == PH_DIGITS && range_ok));
        fin_mag   = (r_phase == PH_ZERO) ? 64'd0 : r_acc;
        fin_value = r_negative ? (64'd0 - fin_mag) : fin_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIGN;
            r_radix     <= RADIX_DEC;
            r_unsigned  <= 1'b0;
            r_negative  <= 1'b0;
            r_acc       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_radix    <= n_radix;
            r_unsigned <= n_unsigned;
            r_negative <= n_negative;
            r_acc      <= n_acc;
            r_err      <= n_err;
            if (take_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_end) begin
            r_out_value <= fin_ok ? fin_value : 64'd0;
            r_out_err   <= !fin_ok;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value_bits  = r_out_value;
    assign o_parse_error = r_out_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_value == 64'd0))
        else $error("error result carries a value");

    a_zero_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ZERO) |-> (r_acc == 64'd0 && r_radix == RADIX_DEC))
        else $error("leading zero phase with nonzero state");

    a_sign_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SIGN) |-> (!r_negative && !r_unsigned && r_acc == 64'd0))
        else $error("sign phase with leftover state");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_end |=> (r_phase == PH_SIGN && !r_err && r_out_valid))
        else $error("end item did not close the string");

endmodule

/* design/integer_string_parser.sv */
// Top level of the integer string parser: front end, token queue, back end.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------
//  input    | push / full        | i_char_code[7:0], i_is_end
//  result   | empty / pop        | o_value_bits[63:0], o_parse_error
//  config   | i_cfg_we           | i_cfg_wdata[6:0] (result width)
//
// One item per cycle on both sides while full is low and results are popped;
// items pass through the token queue register, and an end item's result is
// registered when taken; each token gets one constant-radix multiply-add.
// full rises when the QUEUE_DEPTH token queue fills; the back end holds end
// items while the result register is occupied and not being popped.
// Synchronous active-low reset clears the queue, the parser and the result valid flag.
module integer_string_parser
    import isp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_char_code,
    input  logic        i_is_end,
    input  logic        push,
    output logic        full,
    output logic [63:0] o_value_bits,
    output logic        o_parse_error,
    output logic        empty,
    input  logic        pop,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata
);

    logic [6:0] r_result_bits;
    t_token     front_token, queue_token;
    logic       queue_push, queue_pop, queue_full, queue_empty;
    logic       out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_bits <= RESULT_BITS_RESET;
        end else if (i_cfg_we) begin
            r_result_bits <= i_cfg_wdata;
        end
    end

    isp_front u_front (
        .i_char_code  (i_char_code),
        .i_is_end     (i_is_end),
        .i_push       (push),
        .i_queue_full (queue_full),
        .o_queue_push (queue_push),
        .o_token      (front_token)
    );

    isp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (queue_push),
        .i_data  (front_token),
        .i_pop   (queue_pop),
        .o_data  (queue_token),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    isp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_result_bits (r_result_bits),
        .i_token       (queue_token),
        .i_token_valid (!queue_empty),
        .o_token_pop   (queue_pop),
        .i_out_pop     (pop),
        .o_out_valid   (out_valid),
        .o_value_bits  (o_value_bits),
        .o_parse_error (o_parse_error)
    );

    assign full  = queue_full;
    assign empty = !out_valid;

endmodule
